// ===== rtl/core/sdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtp_pkg: shared types and constants of the sorted deadline timer pool
// Word layouts, slot modes, operation codes and the cell format of the
// sorted chain.
// ----------------------------------------------------------------------------
`default_nettype none
package sdtp_pkg;

  localparam int SLOT_COUNT = 512;
  localparam int OWNER_BITS = 8;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int CELL_COUNT = SLOT_COUNT - 1;
  localparam int ID_W       = 9;
  localparam int COUNT_W    = 10;
  localparam int DL_W       = 32;
  localparam logic [DL_W-1:0] FAR_DEADLINE = 32'hffffffff;

  typedef enum logic [2:0] {
    KIND_ALLOC      = 3'd0,
    KIND_FREE       = 3'd1,
    KIND_INIT       = 3'd2,
    KIND_SET        = 3'd3,
    KIND_CANCEL     = 3'd4,
    KIND_CANCEL_ALL = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOTHING = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_UNUSED = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_QUEUED = 2'd2
  } mode_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] slot_id;
    logic [7:0]      owner_id;
    logic            cancellable;
    logic [DL_W-1:0] delay_ticks;
    logic [DL_W-1:0] now_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    given_slot;
    logic [COUNT_W-1:0] cancelled_count;
    logic [DL_W-1:0]    head_deadline;
  } out_word_t;

  // per-slot bookkeeping kept in RAM
  typedef struct packed {
    logic [1:0]            mode;
    logic                  canc;
    logic [OWNER_BITS-1:0] owner;
  } slot_word_t;

  // one queued entry of the sorted chain
  typedef struct packed {
    logic                 v;
    logic [SLOT_BITS-1:0] slot;
    logic [DL_W-1:0]      dl;
  } cell_t;

  // broadcast command to every cell
  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic [SLOT_BITS-1:0] slot;
    logic [DL_W-1:0]      dl;
  } chain_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdtp_ram.sv =====
// ----------------------------------------------------------------------------
// sdtp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sdtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// ===== rtl/core/sdtp_cell.sv =====
// ----------------------------------------------------------------------------
// sdtp_cell: one cell of the sorted deadline chain
// Takes part in a systolic insert, drops a deleted entry and pulls its right
// neighbour into a hole so that the chain stays packed.
// ----------------------------------------------------------------------------
`default_nettype none
module sdtp_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sdtp_pkg::chain_cmd_t cmd,
  input  wire sdtp_pkg::cell_t    left_cell,
  input  wire logic               left_ge,
  input  wire sdtp_pkg::cell_t    right_cell,
  output      sdtp_pkg::cell_t    cur_cell,
  output      logic               ge
);
  import sdtp_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;
  cell_t moved;

  // new deadline belongs at or before this cell
  assign ge = !cell_r.v || (cmd.dl <= cell_r.dl);

  always_comb begin
    moved    = cell_r;
    cell_nxt = cell_r;
    if (cmd.ins) begin
      // shift right behind the insert point, take the new word at it
      if (left_ge) begin
        cell_nxt = left_cell;
      end else if (ge) begin
        cell_nxt = '{v: 1'b1, slot: cmd.slot, dl: cmd.dl};
      end
    end else begin
      // close holes: pull from the right, hand over to the left
      if (!cell_r.v && right_cell.v) begin
        moved = right_cell;
      end else if (cell_r.v && !left_cell.v) begin
        moved.v = 1'b0;
      end
      cell_nxt = moved;
      // drop the entry being unlinked
      if (cmd.del && moved.v && (moved.slot == cmd.slot)) begin
        cell_nxt.v = 1'b0;
      end
    end
  end

  // hold occupancy and payload; only occupancy is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.v    <= 1'b0;
      cell_r.slot <= cell_nxt.slot;
      cell_r.dl   <= cell_nxt.dl;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cur_cell = cell_r;
endmodule
`default_nettype wire

// ===== rtl/core/sdtp_chain.sv =====
// ----------------------------------------------------------------------------
// sdtp_chain: row of cells holding the queued timers sorted by deadline
// The sentinel is implicit behind the last cell; the head is cell zero.
// ----------------------------------------------------------------------------
`default_nettype none
module sdtp_chain (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sdtp_pkg::chain_cmd_t cmd,
  output      sdtp_pkg::cell_t      head_cell
);
  import sdtp_pkg::*;

  localparam cell_t LEFT_EDGE  = '{v: 1'b1, slot: '0, dl: '0};
  localparam cell_t RIGHT_EDGE = '{v: 1'b0, slot: '0, dl: '0};

  cell_t cells [CELL_COUNT];
  logic  ge_vec [CELL_COUNT];

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    cell_t left_c;
    cell_t right_c;
    logic  left_g;

    // wire neighbours, with fixed edges at both ends
    if (i == 0) begin : g_first
      assign left_c = LEFT_EDGE;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_c = cells[i-1];
      assign left_g = ge_vec[i-1];
    end
    if (i == CELL_COUNT - 1) begin : g_last
      assign right_c = RIGHT_EDGE;
    end else begin : g_inner
      assign right_c = cells[i+1];
    end

    sdtp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_cell  (left_c),
      .left_ge    (left_g),
      .right_cell (right_c),
      .cur_cell   (cells[i]),
      .ge         (ge_vec[i])
    );
  end

  assign head_cell = cells[0];
endmodule
`default_nettype wire

// ===== rtl/core/sorted_deadline_timer_pool.sv =====
// Flow: one word in flight; a new input word is taken only once the result word
//   of the last one has been loaded into the output register.
// The slot scan reads the slot RAM one entry a cycle; a free or cancel of a
//   queued slot, and every cancel_all, ends in a settle phase while the cell
//   chain compacts.
// Reset: synchronous, active low; then a clearing pass over every entry of the
//   slot RAM, during which in_stall stays high.
// ----------------------------------------------------------------------------
// sorted_deadline_timer_pool: timer slot pool with deadline-sorted queue
// Slot modes, owners and cancellable marks live in RAM; queued timers live
// in a chain of cells kept sorted by deadline.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_deadline_timer_pool (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire sdtp_pkg::in_word_t  in_word,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      sdtp_pkg::out_word_t out_word
);
  import sdtp_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOOK   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_SETTLE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  localparam int SETTLE_LEN = 2 * SLOT_COUNT;
  localparam int SETTLE_W   = $clog2(SETTLE_LEN + 1);
  localparam int EXT_W      = SLOT_BITS + ID_W;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

  state_t               state_r, state_nxt;
  in_word_t             item_r, item_nxt;
  logic [SLOT_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [SLOT_BITS-1:0] scan_addr_r, scan_addr_nxt;
  logic                 issue_done_r, issue_done_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [SLOT_BITS-1:0] chk_addr_r, chk_addr_nxt;
  logic [SLOT_BITS-1:0] count_r, count_nxt;
  logic [SLOT_BITS-1:0] given_r, given_nxt;
  status_t              status_r, status_nxt;
  logic [SETTLE_W-1:0]  settle_r, settle_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_r, out_nxt;

  logic                 ram_we, ram_re;
  logic [SLOT_BITS-1:0] ram_waddr, ram_raddr;
  slot_word_t           ram_wdata, ram_rdata;
  chain_cmd_t           cmd;
  cell_t                head_cell;

  logic                 accept;
  logic [EXT_W-1:0]     in_ext, item_ext;
  logic                 item_ok;
  logic [SLOT_BITS-1:0] item_idx;
  logic [OWNER_BITS-1:0] item_owner;

  sdtp_ram #(
    .WIDTH ($bits(slot_word_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sdtp_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .head_cell (head_cell)
  );

  // decode slot index and range
  assign accept     = in_valid && !in_stall;
  assign in_ext     = EXT_W'(in_word.slot_id);
  assign item_ext   = EXT_W'(item_r.slot_id);
  assign item_idx   = item_ext[SLOT_BITS-1:0];
  assign item_ok    = (item_ext < EXT_W'(SLOT_COUNT)) && (item_ext != '0);
  assign item_owner = OWNER_BITS'(item_r.owner_id);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    clr_addr_nxt   = clr_addr_r;
    scan_addr_nxt  = scan_addr_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_addr_nxt   = chk_addr_r;
    count_nxt      = count_r;
    given_nxt      = given_r;
    status_nxt     = status_r;
    settle_nxt     = settle_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    ram_we         = 1'b0;
    ram_waddr      = item_idx;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = in_ext[SLOT_BITS-1:0];
    cmd            = '{ins: 1'b0, del: 1'b0, slot: item_idx,
                       dl: item_r.delay_ticks + item_r.now_ticks};

    case (state_r)
      S_CLEAR: begin
        // sweep the slot RAM, sentinel queued
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '{mode: (clr_addr_r == '0) ? MODE_QUEUED : MODE_UNUSED,
                      canc: 1'b0, owner: '0};
        clr_addr_nxt = SLOT_BITS'(clr_addr_r + 1'b1);
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // take a word and start its operation
        if (accept) begin
          item_nxt       = in_word;
          count_nxt      = '0;
          given_nxt      = '0;
          status_nxt     = ST_NOTHING;
          scan_addr_nxt  = SLOT_BITS'(1);
          issue_done_nxt = 1'b0;
          ram_re         = 1'b1;
          case (in_word.kind)
            KIND_ALLOC, KIND_CANCEL_ALL: state_nxt = S_SCAN;
            KIND_FREE, KIND_INIT, KIND_SET, KIND_CANCEL: state_nxt = S_LOOK;
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_LOOK: begin
        // act on one slot read last cycle
        state_nxt = S_FINISH;
        if (!item_ok) begin
          status_nxt = ST_REFUSED;
        end else begin
          case (item_r.kind)
            KIND_FREE: begin
              if (ram_rdata.mode == MODE_UNUSED) begin
                status_nxt = ST_NOTHING;
              end else begin
                status_nxt     = ST_DONE;
                ram_we         = 1'b1;
                ram_wdata.mode = MODE_UNUSED;
                if (ram_rdata.mode == MODE_QUEUED) begin
                  cmd.del   = 1'b1;
                  state_nxt = S_SETTLE;
                end
              end
            end
            KIND_INIT: begin
              status_nxt      = ST_DONE;
              ram_we          = 1'b1;
              ram_wdata.canc  = item_r.cancellable;
              ram_wdata.owner = item_owner;
            end
            KIND_SET: begin
              if (ram_rdata.mode != MODE_ALLOC) begin
                status_nxt = ST_REFUSED;
              end else begin
                status_nxt     = ST_DONE;
                cmd.ins        = 1'b1;
                ram_we         = 1'b1;
                ram_wdata.mode = MODE_QUEUED;
              end
            end
            KIND_CANCEL: begin
              if (ram_rdata.mode == MODE_QUEUED) begin
                status_nxt     = ST_DONE;
                count_nxt      = SLOT_BITS'(1);
                cmd.del        = 1'b1;
                ram_we         = 1'b1;
                ram_wdata.mode = MODE_ALLOC;
                state_nxt      = S_SETTLE;
              end
            end
            default: status_nxt = ST_NOTHING;
          endcase
        end
        settle_nxt = SETTLE_W'(SETTLE_LEN);
      end
      S_SCAN: begin
        // issue reads one slot a cycle
        if (!issue_done_r) begin
          ram_re        = 1'b1;
          ram_raddr     = scan_addr_r;
          chk_vld_nxt   = 1'b1;
          chk_addr_nxt  = scan_addr_r;
          scan_addr_nxt = SLOT_BITS'(scan_addr_r + 1'b1);
          if (scan_addr_r == LAST_SLOT) begin
            issue_done_nxt = 1'b1;
          end
        end
        // check the slot read last cycle
        ram_waddr = chk_addr_r;
        if (chk_vld_r) begin
          if (item_r.kind == KIND_ALLOC) begin
            if (ram_rdata.mode == MODE_UNUSED) begin
              ram_we         = 1'b1;
              ram_wdata.mode = MODE_ALLOC;
              ram_wdata.canc = 1'b0;
              given_nxt      = chk_addr_r;
              status_nxt     = ST_DONE;
              chk_vld_nxt    = 1'b0;
              state_nxt      = S_FINISH;
            end else if (chk_addr_r == LAST_SLOT) begin
              state_nxt = S_FINISH;
            end
          end else begin
            if ((ram_rdata.mode != MODE_UNUSED) && ram_rdata.canc &&
                (ram_rdata.owner == item_owner)) begin
              ram_we         = 1'b1;
              ram_wdata.mode = MODE_UNUSED;
              count_nxt      = SLOT_BITS'(count_r + 1'b1);
              status_nxt     = ST_DONE;
              cmd.slot       = chk_addr_r;
              cmd.del        = (ram_rdata.mode == MODE_QUEUED);
            end
            if (chk_addr_r == LAST_SLOT) begin
              state_nxt = S_SETTLE;
            end
          end
        end
        settle_nxt = SETTLE_W'(SETTLE_LEN);
      end
      S_SETTLE: begin
        // let the chain close its holes
        settle_nxt = SETTLE_W'(settle_r - 1'b1);
        if (settle_r == '0) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // load the result word when the output side is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_nxt.status          = status_r;
          out_nxt.given_slot      = ID_W'(given_r);
          out_nxt.cancelled_count = COUNT_W'(count_r);
          out_nxt.head_deadline   = head_cell.v ? head_cell.dl : FAR_DEADLINE;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    scan_addr_r  <= scan_addr_nxt;
    issue_done_r <= issue_done_nxt;
    chk_addr_r   <= chk_addr_nxt;
    count_r      <= count_nxt;
    given_r      <= given_nxt;
    status_r     <= status_nxt;
    settle_r     <= settle_nxt;
    out_r        <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // an insert never overlaps an unlink
  a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.del))
    else $error("chain insert and unlink in the same cycle");

  // no word taken during the clearing pass
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");

  // a handed-out slot always comes with a done status
  a_given_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.given_slot != '0)) |-> (out_word.status == ST_DONE))
    else $error("slot handed out without done status");

  // status stays within its codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status != 2'd3))
    else $error("invalid status code");
endmodule
`default_nettype wire

// ===== tb/sv/sorted_deadline_timer_pool_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_deadline_timer_pool_tb: self-checking bench for the timer slot pool
// Drives alloc, free, init, set, cancel, cancel_all and unknown words with random
// gaps and back-pressure. An internal slot-pool model predicts every result word,
// and each accepted result word is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_deadline_timer_pool_tb;
  import sdtp_pkg::*;

  localparam int        SETTLE_CYCLES = 4 * SLOT_COUNT;
  localparam longint    CYCLE_LIMIT   = 40000000;
  localparam int        RANDOM_ITEMS  = 400;
  localparam int        FULL_ITEMS    = 240;
  localparam logic [2:0] KIND_BAD_6   = 3'd6;
  localparam logic [2:0] KIND_BAD_7   = 3'd7;

  // Pool model: predicts result words and holds the ones still owed
  class pool_scoreboard;
    mode_t             mode [SLOT_COUNT];
    bit                canc [SLOT_COUNT];
    bit [7:0]          owner [SLOT_COUNT];
    bit                owner_known [SLOT_COUNT];
    bit [DL_W-1:0]     deadline [SLOT_COUNT];
    bit [ID_W-1:0]     link [SLOT_COUNT];
    bit [ID_W-1:0]     head;
    bit [DL_W-1:0]     earliest;
    out_word_t         owed [$];
    int                errors;
    int                checked;
    int                kind_seen [8];

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        mode[i] = MODE_UNUSED;
        canc[i] = 0;
        owner[i] = '0;
        owner_known[i] = 0;
        deadline[i] = '0;
        link[i] = '0;
      end
      mode[0] = MODE_QUEUED;
      deadline[0] = FAR_DEADLINE;
      head = '0;
      earliest = FAR_DEADLINE;
      errors = 0;
      checked = 0;
    endfunction

    // take a queued slot out of the chain; it falls back to allocated
    function void unlink(bit [ID_W-1:0] s);
      bit [ID_W-1:0] p;
      int steps;
      if (head == s) begin
        head = link[s];
        earliest = deadline[head];
      end else begin
        p = head;
        steps = 0;
        while (link[p] != s && steps < SLOT_COUNT) begin
          p = link[p];
          steps++;
        end
        if (link[p] == s) link[p] = link[s];
      end
      mode[s] = MODE_ALLOC;
    endfunction

    // place before the first entry whose deadline is not smaller
    function void insert(bit [ID_W-1:0] s, bit [DL_W-1:0] dl);
      bit [ID_W-1:0] t, prev;
      bit has_prev;
      int steps;
      t = head;
      prev = '0;
      has_prev = 0;
      steps = 0;
      deadline[s] = dl;
      while (dl > deadline[t] && steps < SLOT_COUNT) begin
        prev = t;
        has_prev = 1;
        t = link[t];
        steps++;
      end
      if (has_prev) link[prev] = s;
      else begin
        head = s;
        earliest = dl;
      end
      link[s] = t;
      mode[s] = MODE_QUEUED;
    endfunction

    // work out the result of an accepted input word and hold it
    function void note_input(in_word_t w);
      out_word_t r;
      bit slot_ok;
      bit [ID_W-1:0] s;
      int cnt;
      s = w.slot_id;
      slot_ok = (s != 0);
      r.status = ST_NOTHING;
      r.given_slot = '0;
      cnt = 0;
      kind_seen[w.kind]++;
      case (w.kind)
        KIND_ALLOC: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (mode[i] == MODE_UNUSED) begin
              mode[i] = MODE_ALLOC;
              canc[i] = 0;
              r.given_slot = i;
              r.status = ST_DONE;
              break;
            end
          end
        end
        KIND_FREE: begin
          if (!slot_ok) r.status = ST_REFUSED;
          else if (mode[s] != MODE_UNUSED) begin
            if (mode[s] == MODE_QUEUED) unlink(s);
            mode[s] = MODE_UNUSED;
            r.status = ST_DONE;
          end
        end
        KIND_INIT: begin
          if (!slot_ok) r.status = ST_REFUSED;
          else begin
            owner[s] = w.owner_id;
            owner_known[s] = 1;
            canc[s] = w.cancellable;
            r.status = ST_DONE;
          end
        end
        KIND_SET: begin
          if (!slot_ok || mode[s] != MODE_ALLOC) r.status = ST_REFUSED;
          else begin
            insert(s, w.delay_ticks + w.now_ticks);
            r.status = ST_DONE;
          end
        end
        KIND_CANCEL: begin
          if (!slot_ok) r.status = ST_REFUSED;
          else if (mode[s] == MODE_QUEUED) begin
            unlink(s);
            cnt = 1;
            r.status = ST_DONE;
          end
        end
        KIND_CANCEL_ALL: begin
          for (int i = 1; i < SLOT_COUNT; i++) begin
            if (mode[i] != MODE_UNUSED && canc[i] && owner[i] == w.owner_id) begin
              if (mode[i] == MODE_QUEUED) unlink(i);
              mode[i] = MODE_UNUSED;
              cnt++;
            end
          end
          r.status = (cnt != 0) ? ST_DONE : ST_NOTHING;
        end
        default: ;
      endcase
      r.cancelled_count = cnt;
      r.head_deadline = earliest;
      owed.push_back(r);
    endfunction

    // compare a result word with the oldest one owed
    function void check_result(out_word_t got);
      out_word_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.given_slot !== want.given_slot) begin
        $display("%0t: given_slot expected %0d actual %0d", $time,
                 want.given_slot, got.given_slot);
        errors++;
      end
      if (got.cancelled_count !== want.cancelled_count) begin
        $display("%0t: cancelled_count expected %0d actual %0d", $time,
                 want.cancelled_count, got.cancelled_count);
        errors++;
      end
      if (got.head_deadline !== want.head_deadline) begin
        $display("%0t: head_deadline expected %h actual %h", $time,
                 want.head_deadline, got.head_deadline);
        errors++;
      end
    endfunction

    function bit pool_full();
      for (int i = 0; i < SLOT_COUNT; i++)
        if (mode[i] == MODE_UNUSED) return 0;
      return 1;
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  pool_scoreboard sb;
  longint         cycle_count;
  int             stall_left;
  bit             long_hold_done;
  bit             calm;

  sorted_deadline_timer_pool uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sorted_deadline_timer_pool_tb failed");
      $finish;
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // receiver stall: short bursts, rare long ones, one very long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      out_stall <= 1'b0;
      if (!long_hold_done && sb.checked >= 300) begin
        stall_left <= 6000;
        long_hold_done <= 1'b1;
      end else if (!calm) begin
        if (r < 12) stall_left <= $urandom_range(1, 3);
        else if (r < 13) stall_left <= $urandom_range(30, 120);
      end
    end
  end

  // no cancel_all may meet a live slot whose owner was never set
  function automatic in_word_t guard_owner(in_word_t w);
    if (w.kind == KIND_CANCEL_ALL) begin
      for (int i = 1; i < SLOT_COUNT; i++) begin
        if (sb.mode[i] != MODE_UNUSED && !sb.owner_known[i]) begin
          w.kind = KIND_INIT;
          w.slot_id = i;
          return w;
        end
      end
    end
    return w;
  endfunction

  // offer one word, hold it until accepted, then idle a random gap
  task automatic send_word(input in_word_t w);
    int g, r;
    w = guard_owner(w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    r = $urandom_range(0, 99);
    if (calm) g = 0;
    else if (r < 60) g = 0;
    else if (r < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(20, 80);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [2:0] k, input int s, input int o, input bit c,
                             input logic [31:0] d, input logic [31:0] n);
    in_word_t w;
    w.kind = k;
    w.slot_id = s;
    w.owner_id = o;
    w.cancellable = c;
    w.delay_ticks = d;
    w.now_ticks = n;
    send_word(w);
  endtask

  // pause the sender until every owed result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t random_word(int alloc_bias);
    in_word_t w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15 + alloc_bias) w.kind = KIND_ALLOC;
    else if (r < 27 + alloc_bias) w.kind = KIND_FREE;
    else if (r < 45 + alloc_bias) w.kind = KIND_INIT;
    else if (r < 70 + alloc_bias) w.kind = KIND_SET;
    else if (r < 82 + alloc_bias) w.kind = KIND_CANCEL;
    else if (r < 97) w.kind = KIND_CANCEL_ALL;
    else w.kind = (r == 98) ? KIND_BAD_6 : (r == 99 ? KIND_BAD_7 : KIND_CANCEL_ALL);
    r = $urandom_range(0, 99);
    if (r < 85) w.slot_id = $urandom_range(1, 14);
    else if (r < 90) w.slot_id = 0;
    else w.slot_id = $urandom;
    w.owner_id = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom;
    w.cancellable = $urandom;
    r = $urandom_range(0, 99);
    w.delay_ticks = (r < 50) ? $urandom_range(0, 1000) : $urandom;
    w.now_ticks = (r < 25 || r >= 75) ? $urandom_range(0, 1000) : $urandom;
    return w;
  endfunction

  initial begin
    in_word_t w;
    sb = new();
    cycle_count = 0;
    stall_left = 0;
    long_hold_done = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: wrap, equal deadlines, refusals, sentinel, unknown kinds
    send_fields(KIND_ALLOC, 0, 0, 0, 0, 0);
    send_fields(KIND_ALLOC, 0, 0, 0, 0, 0);
    send_fields(KIND_INIT, 1, 8'hff, 1, 0, 0);
    send_fields(KIND_INIT, 2, 8'h00, 0, 0, 0);
    send_fields(KIND_SET, 1, 0, 0, 32'd100, 32'hffffffff);
    send_fields(KIND_SET, 2, 0, 0, 32'hffffffff, 32'd0);
    send_fields(KIND_SET, 1, 0, 0, 32'd5, 32'd5);
    send_fields(KIND_SET, 3, 0, 0, 32'd5, 32'd5);
    send_fields(KIND_SET, 0, 0, 0, 32'd1, 32'd1);
    send_fields(KIND_FREE, 0, 0, 0, 0, 0);
    send_fields(KIND_INIT, 0, 8'h11, 1, 0, 0);
    send_fields(KIND_CANCEL, 0, 0, 0, 0, 0);
    send_fields(KIND_CANCEL, 3, 0, 0, 0, 0);
    send_fields(KIND_CANCEL, 2, 0, 0, 0, 0);
    send_fields(KIND_SET, 2, 0, 0, 32'd0, 32'd0);
    send_fields(KIND_FREE, 1, 0, 0, 0, 0);
    send_fields(KIND_FREE, 1, 0, 0, 0, 0);
    send_fields(KIND_BAD_6, 9'h1ff, 8'hff, 1, 32'hffffffff, 32'hffffffff);
    send_fields(KIND_BAD_7, 0, 0, 0, 0, 0);
    send_fields(KIND_INIT, 511, 8'hff, 1, 0, 0);
    send_fields(KIND_ALLOC, 0, 0, 0, 0, 0);
    send_fields(KIND_INIT, 1, 8'hff, 1, 0, 0);
    send_fields(KIND_SET, 1, 0, 0, 32'd0, 32'd0);
    send_fields(KIND_CANCEL_ALL, 0, 8'hff, 0, 0, 0);
    send_fields(KIND_CANCEL_ALL, 0, 8'hff, 0, 0, 0);

    // random mix, with one calm stretch and one full drain
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 200 && i < 260);
      if (i == 300) drain();
      send_word(random_word(0));
    end
    calm = 1'b0;

    // fill the pool up to full, then knock on it a few more times
    while (!sb.pool_full()) send_fields(KIND_ALLOC, 0, 0, 0, 0, 0);
    repeat (3) send_fields(KIND_ALLOC, 0, 0, 0, 0, 0);
    send_fields(KIND_INIT, 511, 8'h80, 1, 0, 0);
    send_fields(KIND_SET, 511, 0, 0, 32'hfffffffe, 32'd1);

    // random mix on a nearly full pool
    for (int i = 0; i < FULL_ITEMS; i++) begin
      w = random_word(-5);
      if ($urandom_range(0, 9) == 0) w.slot_id = $urandom_range(15, 511);
      send_word(w);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, sb.owed.size());
      sb.errors++;
    end
    $display("Checked %0d result words: alloc %0d, free %0d, init %0d, set %0d,",
             sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
    $display("cancel %0d, cancel_all %0d, unknown %0d, including a full pool.",
             sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6] + sb.kind_seen[7]);
    if (sb.errors == 0) begin
      $display("sorted_deadline_timer_pool_tb passed");
    end else begin
      $display("sorted_deadline_timer_pool_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/sdtp_pkg.sv
rtl/core/sdtp_ram.sv
rtl/core/sdtp_cell.sv
rtl/core/sdtp_chain.sv
rtl/core/sorted_deadline_timer_pool.sv
tb/sv/sorted_deadline_timer_pool_tb.sv
